[rtl/line_sensor_position_calibrator_defines.svh]
// assertion macros for the line sensor position calibrator
`ifndef LINE_SENSOR_POSITION_CALIBRATOR_DEFINES_SVH
`define LINE_SENSOR_POSITION_CALIBRATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LSPC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lspc assertion failed");

// next-cycle implication, disabled while reset is low
`define LSPC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lspc assertion failed");

`endif

[rtl/lspc_pkg.sv]
// shared constants, types and helpers of the line sensor position calibrator
`timescale 1ns / 1ps

package lspc_pkg;

  // sensor row and weighting
  localparam int NUM_SENSORS     = 5;
  localparam int POSITION_WEIGHT = 1000;
  localparam int SENSOR_SLOTS    = 5;
  localparam int SENSOR_W        = 16;
  localparam int POS_W           = 15;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // register reset values
  localparam logic [SENSOR_W-1:0] FS_RESET  = 16'd2000;
  localparam logic [SENSOR_W-1:0] THR_RESET = 16'd200;

  // derived widths
  localparam int IDX_W   = $clog2(NUM_SENSORS);
  localparam int WGT_W   = $clog2((NUM_SENSORS - 1) * POSITION_WEIGHT + 1);
  localparam int PROD_W  = SENSOR_W + WGT_W;
  localparam longint unsigned NUM_MAX = longint'(NUM_SENSORS * (NUM_SENSORS - 1) / 2)
                                        * longint'(POSITION_WEIGHT) * 64'd65535;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int DEN_W   = $clog2(NUM_SENSORS * 65535 + 1);
  localparam int EDGE_W  = $clog2((NUM_SENSORS - 1) * 65535 + 1);
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SENSORS - 1);

  // configuration register indexes
  localparam logic REG_FULL_SCALE = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_CALIB  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CAL_OK          = 2'd0,
    CAL_NOT_STARTED = 2'd1,
    CAL_SPAN_LOW    = 2'd2
  } cal_status_e;

  typedef enum logic [1:0] {
    CAL_OP_NONE   = 2'd0,
    CAL_OP_UPDATE = 2'd1,
    CAL_OP_CLEAR  = 2'd2
  } cal_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV,
    ST_STATUS,
    ST_DONE
  } seq_state_e;

  // command from the sequencer to the calibration store
  typedef struct packed {
    cal_op_e          op;
    logic [IDX_W-1:0] idx;
  } cal_cmd_t;

  // position weight of a sensor index
  function automatic logic [WGT_W-1:0] sensor_weight(input logic [IDX_W-1:0] idx);
    return WGT_W'(int'(idx) * POSITION_WEIGHT);
  endfunction

endpackage

[rtl/lspc_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lspc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lspc_pkg::NUM_W-1:0]      dividend_i,
  input  logic [lspc_pkg::DEN_W-1:0]      divisor_i,
  output logic                            done_o,
  output logic [lspc_pkg::NUM_W-1:0]      quotient_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [lspc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [lspc_pkg::NUM_W-1:0]      quo_q, quo_d;
  logic [lspc_pkg::DEN_W-1:0]      rem_q, rem_d;
  logic [lspc_pkg::DEN_W-1:0]      den_q, den_d;
  logic [lspc_pkg::DEN_W:0]        trial;
  logic [lspc_pkg::DEN_W:0]        diff;
  logic                            fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[lspc_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // step control and datapath
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = lspc_pkg::CNT_W'(lspc_pkg::NUM_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[lspc_pkg::DEN_W-1:0] : trial[lspc_pkg::DEN_W-1:0];
      quo_d = {quo_q[lspc_pkg::NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == lspc_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/lspc_calib.sv]
// per-sensor minimum and maximum store with span check
`timescale 1ns / 1ps

module lspc_calib (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [lspc_pkg::SENSOR_W-1:0]     full_scale_i,
  input  lspc_pkg::cal_cmd_t                cmd_i,
  input  logic [lspc_pkg::SENSOR_W-1:0]     reading_i,
  output logic                              started_o,
  output logic                              span_low_o
);

  logic [lspc_pkg::SENSOR_W-1:0] min_q [lspc_pkg::NUM_SENSORS];
  logic [lspc_pkg::SENSOR_W-1:0] min_d [lspc_pkg::NUM_SENSORS];
  logic [lspc_pkg::SENSOR_W-1:0] max_q [lspc_pkg::NUM_SENSORS];
  logic [lspc_pkg::SENSOR_W-1:0] max_d [lspc_pkg::NUM_SENSORS];
  logic                          started_q, started_d;
  logic [lspc_pkg::SENSOR_W-1:0] sel_min;
  logic [lspc_pkg::SENSOR_W-1:0] sel_max;
  logic [lspc_pkg::SENSOR_W-1:0] span;

  assign sel_min = min_q[cmd_i.idx];
  assign sel_max = max_q[cmd_i.idx];

  // update or clear the addressed entry
  always_comb begin
    min_d     = min_q;
    max_d     = max_q;
    started_d = started_q;
    unique case (cmd_i.op)
      lspc_pkg::CAL_OP_UPDATE: begin
        if (reading_i < sel_min) begin
          min_d[cmd_i.idx] = reading_i;
        end
        if (reading_i > sel_max) begin
          max_d[cmd_i.idx] = reading_i;
        end
        started_d = 1'b1;
      end
      lspc_pkg::CAL_OP_CLEAR: begin
        min_d[cmd_i.idx] = full_scale_i;
        max_d[cmd_i.idx] = '0;
        started_d        = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lspc_pkg::NUM_SENSORS; i++) begin
        min_q[i] <= lspc_pkg::FS_RESET;
        max_q[i] <= '0;
      end
      started_q <= 1'b0;
    end else begin
      min_q     <= min_d;
      max_q     <= max_d;
      started_q <= started_d;
    end
  end

  // span of the addressed sensor against a quarter of full scale
  assign span       = (sel_max > sel_min) ? (sel_max - sel_min) : '0;
  assign span_low_o = span < (full_scale_i >> 2);
  assign started_o  = started_q;

endmodule

[rtl/line_sensor_position_calibrator.sv]
// top level: sequencer, accumulators, config registers and result register
`timescale 1ns / 1ps
`include "line_sensor_position_calibrator_defines.svh"

// Line sensor position calibrator.
// Input channel (in_valid_i/in_ready_o) takes one frame: a kind and five raw
// sensor readings. Kind 0 reads the line position as a weighted centroid,
// kind 1 widens the per-sensor min/max, kind 2 clears calibration.
// Output channel (out_valid_o/out_ready_i) gives one result per frame:
// position, on_line, calib_status and failing_sensor.
// Configuration: cfg_we_i writes cfg_wdata_i into full_scale (index 0) or
// off_line_threshold (index 1) at once; write only while the block is idle.
// The block takes one frame at a time. A frame walks the sensors one per
// cycle, takes a decision step, then for an on-line read runs the
// restoring divider, one quotient bit per cycle for a 30-bit quotient,
// then checks calibration spans one sensor per cycle (stopping at once
// before calibration starts), then waits in a done state. The next
// frame can be taken in the same cycle as the earliest result accept.
// The result sits in an output register, so the next frame is accepted
// while it waits; a stalled receiver holds the block only when a second
// result is ready before the first is taken.
// Reset clears calibration (min to 2000, max to 0), the last position and
// both config registers to their defaults; no clearing pass is needed.

module line_sensor_position_calibrator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write port
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [lspc_pkg::SENSOR_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      kind_i,
  input  logic [lspc_pkg::SENSOR_W-1:0]   sensor_0_i,
  input  logic [lspc_pkg::SENSOR_W-1:0]   sensor_1_i,
  input  logic [lspc_pkg::SENSOR_W-1:0]   sensor_2_i,
  input  logic [lspc_pkg::SENSOR_W-1:0]   sensor_3_i,
  input  logic [lspc_pkg::SENSOR_W-1:0]   sensor_4_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lspc_pkg::POS_W-1:0]      position_o,
  output logic                            on_line_o,
  output logic [1:0]                      calib_status_o,
  output logic [2:0]                      failing_sensor_o
);

  lspc_pkg::seq_state_e           state_q, state_d;
  logic [lspc_pkg::IDX_W-1:0]     idx_q, idx_d;
  lspc_pkg::kind_e                kind_q, kind_d;
  logic [lspc_pkg::SENSOR_W-1:0]  rd_q [lspc_pkg::NUM_SENSORS];
  logic [lspc_pkg::SENSOR_W-1:0]  rd_d [lspc_pkg::NUM_SENSORS];
  logic [lspc_pkg::SENSOR_W-1:0]  in_rd [lspc_pkg::SENSOR_SLOTS];
  logic [lspc_pkg::NUM_W-1:0]     num_q, num_d;
  logic [lspc_pkg::DEN_W-1:0]     den_q, den_d;
  logic                           seen_q, seen_d;
  logic [lspc_pkg::POS_W-1:0]     pos_q, pos_d;
  logic                           on_line_q, on_line_d;
  lspc_pkg::cal_status_e          status_q, status_d;
  logic [lspc_pkg::IDX_W-1:0]     fail_q, fail_d;
  logic [lspc_pkg::POS_W-1:0]     last_pos_q, last_pos_d;
  logic [lspc_pkg::SENSOR_W-1:0]  fs_q;
  logic [lspc_pkg::SENSOR_W-1:0]  thr_q;
  logic                           out_valid_q, out_valid_d;
  logic [lspc_pkg::POS_W-1:0]     out_pos_q;
  logic                           out_on_line_q;
  lspc_pkg::cal_status_e          out_status_q;
  logic [2:0]                     out_fail_q;

  logic                           accept;
  logic                           out_free;
  logic                           go_div;
  logic [lspc_pkg::SENSOR_W-1:0]  cur_rd;
  logic [lspc_pkg::PROD_W-1:0]    prod;
  logic [lspc_pkg::EDGE_W-1:0]    edge_pos;
  logic [lspc_pkg::POS_W-1:0]     edge_sat;
  logic [lspc_pkg::POS_W-1:0]     quo_sat;
  lspc_pkg::cal_cmd_t             cal_cmd;
  logic                           cal_started;
  logic                           cal_span_low;
  logic                           div_done;
  logic [lspc_pkg::NUM_W-1:0]     div_quo;

  assign in_ready_o = (state_q == lspc_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_rd[0] = sensor_0_i;
  assign in_rd[1] = sensor_1_i;
  assign in_rd[2] = sensor_2_i;
  assign in_rd[3] = sensor_3_i;
  assign in_rd[4] = sensor_4_i;

  // current sensor term of the weighted sum
  assign cur_rd = rd_q[idx_q];
  assign prod   = {{lspc_pkg::WGT_W{1'b0}}, cur_rd}
                * {{lspc_pkg::SENSOR_W{1'b0}}, lspc_pkg::sensor_weight(idx_q)};

  // far-right edge position and saturated values
  assign edge_pos = lspc_pkg::EDGE_W'(lspc_pkg::NUM_SENSORS - 1)
                  * lspc_pkg::EDGE_W'(fs_q);
  assign edge_sat = (edge_pos > lspc_pkg::EDGE_W'(lspc_pkg::POS_MAX))
                  ? lspc_pkg::POS_MAX : edge_pos[lspc_pkg::POS_W-1:0];
  assign quo_sat  = (div_quo > lspc_pkg::NUM_W'(lspc_pkg::POS_MAX))
                  ? lspc_pkg::POS_MAX : div_quo[lspc_pkg::POS_W-1:0];

  assign go_div = (state_q == lspc_pkg::ST_DECIDE) && (kind_q == lspc_pkg::KIND_READ)
               && seen_q && (den_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lspc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lspc_pkg::ST_SCAN;
        end
      end
      lspc_pkg::ST_SCAN: begin
        if (idx_q == lspc_pkg::LAST_IDX) begin
          state_d = lspc_pkg::ST_DECIDE;
        end
      end
      lspc_pkg::ST_DECIDE: begin
        state_d = go_div ? lspc_pkg::ST_DIV : lspc_pkg::ST_STATUS;
      end
      lspc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lspc_pkg::ST_STATUS;
        end
      end
      lspc_pkg::ST_STATUS: begin
        if (!cal_started || cal_span_low || idx_q == lspc_pkg::LAST_IDX) begin
          state_d = lspc_pkg::ST_DONE;
        end
      end
      lspc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lspc_pkg::ST_IDLE;
        end
      end
      default: state_d = lspc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    idx_d       = idx_q;
    kind_d      = kind_q;
    rd_d        = rd_q;
    num_d       = num_q;
    den_d       = den_q;
    seen_d      = seen_q;
    pos_d       = pos_q;
    on_line_d   = on_line_q;
    status_d    = status_q;
    fail_d      = fail_q;
    last_pos_d  = last_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cal_cmd.op  = lspc_pkg::CAL_OP_NONE;
    cal_cmd.idx = idx_q;
    unique case (state_q)
      lspc_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d = lspc_pkg::kind_e'(kind_i);
          for (int i = 0; i < lspc_pkg::NUM_SENSORS; i++) begin
            rd_d[i] = in_rd[i];
          end
          idx_d  = '0;
          num_d  = '0;
          den_d  = '0;
          seen_d = 1'b0;
        end
      end
      lspc_pkg::ST_SCAN: begin
        num_d  = num_q + lspc_pkg::NUM_W'(prod);
        den_d  = den_q + lspc_pkg::DEN_W'(cur_rd);
        seen_d = seen_q || (cur_rd > thr_q);
        case (kind_q)
          lspc_pkg::KIND_CALIB: cal_cmd.op = lspc_pkg::CAL_OP_UPDATE;
          lspc_pkg::KIND_CLEAR: cal_cmd.op = lspc_pkg::CAL_OP_CLEAR;
          default:              cal_cmd.op = lspc_pkg::CAL_OP_NONE;
        endcase
        idx_d = (idx_q == lspc_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;
      end
      lspc_pkg::ST_DECIDE: begin
        pos_d     = '0;
        on_line_d = 1'b0;
        if (kind_q == lspc_pkg::KIND_READ) begin
          if (seen_q) begin
            on_line_d = 1'b1;
            if (den_q == '0) begin
              last_pos_d = '0;
            end
          end else if (lspc_pkg::EDGE_W'(last_pos_q) >= (edge_pos >> 1)) begin
            pos_d = edge_sat;
          end
        end
      end
      lspc_pkg::ST_DIV: begin
        if (div_done) begin
          pos_d      = quo_sat;
          last_pos_d = quo_sat;
        end
      end
      lspc_pkg::ST_STATUS: begin
        if (!cal_started) begin
          status_d = lspc_pkg::CAL_NOT_STARTED;
          fail_d   = '0;
        end else if (cal_span_low) begin
          status_d = lspc_pkg::CAL_SPAN_LOW;
          fail_d   = idx_q;
        end else if (idx_q == lspc_pkg::LAST_IDX) begin
          status_d = lspc_pkg::CAL_OK;
          fail_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      lspc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      last_pos_q  <= '0;
      fs_q        <= lspc_pkg::FS_RESET;
      thr_q       <= lspc_pkg::THR_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_pos_q  <= last_pos_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == lspc_pkg::REG_FULL_SCALE) begin
          fs_q <= cfg_wdata_i;
        end else begin
          thr_q <= cfg_wdata_i;
        end
      end
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    kind_q    <= kind_d;
    rd_q      <= rd_d;
    num_q     <= num_d;
    den_q     <= den_d;
    seen_q    <= seen_d;
    pos_q     <= pos_d;
    on_line_q <= on_line_d;
    status_q  <= status_d;
    fail_q    <= fail_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == lspc_pkg::ST_DONE && out_free) begin
      out_pos_q     <= pos_q;
      out_on_line_q <= on_line_q;
      out_status_q  <= status_q;
      out_fail_q    <= 3'(fail_q);
    end
  end

  lspc_calib u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .full_scale_i(fs_q),
    .cmd_i       (cal_cmd),
    .reading_i   (cur_rd),
    .started_o   (cal_started),
    .span_low_o  (cal_span_low)
  );

  lspc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (go_div),
    .dividend_i(num_q),
    .divisor_i (den_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign out_valid_o      = out_valid_q;
  assign position_o       = out_pos_q;
  assign on_line_o        = out_on_line_q;
  assign calib_status_o   = out_status_q;
  assign failing_sensor_o = out_fail_q;

  // checks
  `LSPC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, !in_ready_o)
  `LSPC_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == lspc_pkg::ST_DIV)
  `LSPC_ASSERT_IMP(a_fail_only_span_low, clk_i, rst_ni,
                   out_valid_o && (calib_status_o != lspc_pkg::CAL_SPAN_LOW),
                   failing_sensor_o == 3'd0)
  `LSPC_ASSERT_NXT(a_hold_when_stalled, clk_i, rst_ni,
                   (state_q == lspc_pkg::ST_DONE) && out_valid_o && !out_ready_i,
                   state_q == lspc_pkg::ST_DONE)

endmodule

[tb/lspc_result_checker.sv]
// result checker for the line sensor position calibrator: predicts and compares
`timescale 1ns / 1ps

module lspc_result_checker
  import lspc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [SENSOR_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          kind_i,
  input  logic [SENSOR_W-1:0] sensor_0_i,
  input  logic [SENSOR_W-1:0] sensor_1_i,
  input  logic [SENSOR_W-1:0] sensor_2_i,
  input  logic [SENSOR_W-1:0] sensor_3_i,
  input  logic [SENSOR_W-1:0] sensor_4_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                on_line_i,
  input  logic [1:0]          calib_status_i,
  input  logic [2:0]          failing_sensor_i,
  output int unsigned         mismatches_o,
  output int unsigned         outstanding_o
);

  typedef logic [SENSOR_SLOTS-1:0][SENSOR_W-1:0] readings_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             on_line;
    cal_status_e      status;
    logic [2:0]       failing;
  } line_result_t;

  // shadow of the block state and registers
  logic [SENSOR_W-1:0] cal_min [SENSOR_SLOTS];
  logic [SENSOR_W-1:0] cal_max [SENSOR_SLOTS];
  logic                cal_started = 1'b0;
  logic [SENSOR_W-1:0] last_pos = '0;
  logic [SENSOR_W-1:0] fs_reg = FS_RESET;
  logic [SENSOR_W-1:0] thr_reg = THR_RESET;

  line_result_t awaited_results [$];
  int unsigned  errors = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // min back to full scale, max to zero
  task automatic clear_calibration();
    for (int i = 0; i < SENSOR_SLOTS; i++) begin
      cal_min[i] = fs_reg;
      cal_max[i] = '0;
    end
    cal_started = 1'b0;
  endtask

  // apply one frame to the shadow state and work out its result
  task automatic advance_calibrator(input kind_e kind, input readings_t rd,
                                    output line_result_t r);
    longint unsigned weighted;
    longint unsigned total;
    longint unsigned quotient;
    int unsigned     edge_pos;
    int unsigned     span;
    bit              seen;
    bit              found;
    r = '0;
    case (kind)
      KIND_READ: begin
        weighted = 0;
        total    = 0;
        seen     = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
          weighted += 64'(i * POSITION_WEIGHT) * 64'(rd[i]);
          total    += 64'(rd[i]);
          if (rd[i] > thr_reg) seen = 1'b1;
        end
        if (seen) begin
          quotient   = (total != 0) ? weighted / total : 64'd0;
          r.position = (quotient > 64'(POS_MAX)) ? POS_MAX : quotient[POS_W-1:0];
          r.on_line  = 1'b1;
          last_pos   = 16'(r.position);
        end else begin
          // off the line: pick the side the line was last seen on
          edge_pos = 32'(NUM_SENSORS - 1) * 32'(fs_reg);
          if (32'(last_pos) < edge_pos / 2) begin
            r.position = '0;
          end else begin
            r.position = (edge_pos > 32'(POS_MAX)) ? POS_MAX : edge_pos[POS_W-1:0];
          end
        end
      end
      KIND_CALIB: begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          if (rd[i] < cal_min[i]) cal_min[i] = rd[i];
          if (rd[i] > cal_max[i]) cal_max[i] = rd[i];
        end
        cal_started = 1'b1;
      end
      KIND_CLEAR: begin
        clear_calibration();
      end
      default: begin
      end
    endcase

    // status is judged on the state after this item
    if (!cal_started) begin
      r.status = CAL_NOT_STARTED;
    end else begin
      r.status = CAL_OK;
      found    = 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        span = (cal_max[i] > cal_min[i]) ? 32'(cal_max[i] - cal_min[i]) : 0;
        if (!found && span < (32'(fs_reg) >> 2)) begin
          found     = 1'b1;
          r.status  = CAL_SPAN_LOW;
          r.failing = 3'(i);
        end
      end
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t want;
    line_result_t got;
    if (!rst_ni) begin
      fs_reg   = FS_RESET;
      thr_reg  = THR_RESET;
      last_pos = '0;
      clear_calibration();
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report("result with nothing awaited, position", position_i, 0);
        end else begin
          want = awaited_results.pop_front();
          if (position_i !== want.position)
            report("position", position_i, want.position);
          if (on_line_i !== want.on_line)
            report("on_line", on_line_i, want.on_line);
          if (calib_status_i !== want.status)
            report("calib_status", calib_status_i, want.status);
          if (failing_sensor_i !== want.failing)
            report("failing_sensor", failing_sensor_i, want.failing);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FULL_SCALE) fs_reg = cfg_wdata_i;
        else if (cfg_idx_i == REG_THRESHOLD) thr_reg = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        advance_calibrator(kind_e'(kind_i),
                           {sensor_4_i, sensor_3_i, sensor_2_i, sensor_1_i, sensor_0_i}, got);
        awaited_results.push_back(got);
      end
    end
    mismatches_o  <= errors;
    outstanding_o <= awaited_results.size();
  end

endmodule

[tb/testbench.sv]
// testbench top for the line sensor position calibrator: stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import lspc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 60;

  typedef struct packed {
    kind_e                                 kind;
    logic [SENSOR_SLOTS-1:0][SENSOR_W-1:0] rd;
  } frame_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [SENSOR_W-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          kind_i;
  logic [SENSOR_W-1:0] sensor_0_i;
  logic [SENSOR_W-1:0] sensor_1_i;
  logic [SENSOR_W-1:0] sensor_2_i;
  logic [SENSOR_W-1:0] sensor_3_i;
  logic [SENSOR_W-1:0] sensor_4_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [POS_W-1:0]    position_o;
  logic                on_line_o;
  logic [1:0]          calib_status_o;
  logic [2:0]          failing_sensor_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned hold_requests = 0;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned cur_fs;
  int unsigned cur_thr;

  line_sensor_position_calibrator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .kind_i,
    .sensor_0_i, .sensor_1_i, .sensor_2_i, .sensor_3_i, .sensor_4_i,
    .out_valid_o, .out_ready_i, .position_o, .on_line_o, .calib_status_o, .failing_sensor_o
  );

  lspc_result_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i (in_ready_o), .kind_i,
    .sensor_0_i, .sensor_1_i, .sensor_2_i, .sensor_3_i, .sensor_4_i,
    .out_valid_i (out_valid_o), .out_ready_i,
    .position_i (position_o), .on_line_i (on_line_o),
    .calib_status_i (calib_status_o), .failing_sensor_i (failing_sensor_o),
    .mismatches_o (mismatches), .outstanding_o (outstanding)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic frame_t make_frame(input kind_e k, input logic [15:0] a, b, c, d, e);
    frame_t f;
    f.kind = k;
    f.rd   = {e, d, c, b, a};
    return f;
  endfunction

  // any kind, any readings, some pinned to the rails
  function automatic frame_t noise_frame();
    frame_t f;
    f.kind = kind_e'($urandom_range(0, 3));
    for (int i = 0; i < SENSOR_SLOTS; i++) begin
      case ($urandom_range(0, 5))
        0:       f.rd[i] = 16'h0000;
        1:       f.rd[i] = 16'hffff;
        default: f.rd[i] = 16'($urandom);
      endcase
    end
    return f;
  endfunction

  // calibration sample: dark, bright, near the span limit or anything
  function automatic frame_t calib_frame();
    frame_t      f;
    int unsigned q;
    q      = cur_fs / 4;
    f.kind = KIND_CALIB;
    for (int i = 0; i < SENSOR_SLOTS; i++) begin
      case ($urandom_range(0, 5))
        0:       f.rd[i] = 16'($urandom_range(0, cur_fs / 8));
        1:       f.rd[i] = 16'($urandom_range(cur_fs - cur_fs / 8, cur_fs));
        2:       f.rd[i] = 16'($urandom_range(0, cur_fs));
        3:       f.rd[i] = 16'($urandom);
        default: f.rd[i] = 16'($urandom_range(q > 2 ? q - 2 : 0, q + 2));
      endcase
    end
    return f;
  endfunction

  // read with a line under one sensor, or now and then off the line
  function automatic frame_t line_frame();
    frame_t      f;
    int unsigned center;
    int unsigned lo;
    int unsigned hi;
    int unsigned peak;
    int unsigned gap;
    center = $urandom_range(0, SENSOR_SLOTS - 1);
    lo     = (cur_thr < 65535) ? cur_thr + 1 : 65535;
    hi     = ($urandom_range(0, 2) == 0) ? 65535 : ((cur_fs > lo) ? cur_fs : lo);
    if (hi > 65535) hi = 65535;
    peak   = $urandom_range(lo, hi);
    f.kind = KIND_READ;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < SENSOR_SLOTS; i++) f.rd[i] = 16'($urandom_range(0, cur_thr));
    end else begin
      for (int i = 0; i < SENSOR_SLOTS; i++) begin
        gap = (i > center) ? i - center : center - i;
        if (gap == 0) f.rd[i] = 16'(peak);
        else if (gap == 1) f.rd[i] = 16'($urandom_range(0, peak));
        else f.rd[i] = 16'($urandom_range(0, cur_thr));
      end
    end
    return f;
  endfunction

  // offer one item and hold it until accepted; starts and ends at a falling edge
  task automatic send_item(input frame_t f);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= f.kind;
    sensor_0_i <= f.rd[0];
    sensor_1_i <= f.rd[1];
    sensor_2_i <= f.rd[2];
    sensor_3_i <= f.rd[3];
    sensor_4_i <= f.rd[4];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [SENSOR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering and wait until every awaited result has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // calibrate-then-read episodes with random content, plus some noise
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned n;
    frame_t      f;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) == 0) begin
          f      = noise_frame();
          f.kind = KIND_CLEAR;
          send_item(f);
          sent++;
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item(calib_frame());
          sent++;
        end
        n = $urandom_range(2, 12);
        repeat (n) begin
          send_item(line_frame());
          sent++;
        end
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          send_item(noise_frame());
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input int unsigned fs, input int unsigned thr, input int unsigned items,
                           input bit tx_idle, input bit rx_idle, input bit with_hold);
    wait_idle();
    write_reg(REG_FULL_SCALE, 16'(fs));
    write_reg(REG_THRESHOLD, 16'(thr));
    cur_fs     = fs;
    cur_thr    = thr;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    if (with_hold) begin
      // receiver stops for a long while, sender keeps pushing reads
      hold_requests++;
      tx_idle_en = 1'b0;
      repeat (12) send_item(line_frame());
      tx_idle_en = tx_idle;
    end
    run_random(items);
  endtask

  // result side: random stalls and the long hold-off
  initial begin
    int unsigned holds_done;
    holds_done  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL line_sensor_position_calibrator");
    $finish;
  end

  // main sequence
  initial begin
    int unsigned fs_rand;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_FULL_SCALE;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_READ;
    sensor_0_i  = '0;
    sensor_1_i  = '0;
    sensor_2_i  = '0;
    sensor_3_i  = '0;
    sensor_4_i  = '0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    cur_fs      = FS_RESET;
    cur_thr     = THR_RESET;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed items at the reset settings (full scale 2000, threshold 200)
    send_item(make_frame(KIND_READ, 0, 0, 0, 0, 0));
    send_item(make_frame(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_item(make_frame(KIND_READ, 0, 0, 0, 0, 16'hffff));
    // off the line after a right-end read: far right answer
    send_item(make_frame(KIND_READ, 0, 0, 0, 0, 0));
    // readings equal to the threshold do not count as on line
    send_item(make_frame(KIND_READ, 200, 200, 200, 200, 200));
    send_item(make_frame(KIND_READ, 201, 0, 0, 0, 0));
    send_item(make_frame(KIND_READ, 0, 0, 0, 0, 0));
    send_item(make_frame(KIND_READ, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_item(make_frame(KIND_READ, 0, 0, 0, 201, 201));
    send_item(make_frame(KIND_READ, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    send_item(make_frame(KIND_READ, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    // span test around a quarter of full scale
    send_item(make_frame(KIND_CALIB, 0, 0, 0, 0, 0));
    send_item(make_frame(KIND_CALIB, 500, 499, 500, 500, 500));
    send_item(make_frame(KIND_CALIB, 500, 500, 2000, 2000, 2000));
    send_item(make_frame(KIND_CALIB, 0, 500, 0, 0, 0));
    send_item(make_frame(KIND_READ, 100, 900, 1500, 700, 50));
    send_item(make_frame(KIND_UNUSED, 1, 2, 3, 4, 5));
    // calibration reset, then a sample above full scale
    send_item(make_frame(KIND_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_item(make_frame(KIND_CALIB, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_item(make_frame(KIND_CALIB, 0, 0, 0, 0, 0));
    send_item(make_frame(KIND_READ, 0, 0, 16'hffff, 0, 0));
    send_item(make_frame(KIND_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_frame(KIND_UNUSED, 0, 0, 0, 0, 0));

    // register settings, extremes among them
    run_phase(2000, 200, 300, 1'b1, 1'b1, 1'b0);
    run_phase(65535, 0, 100, 1'b1, 1'b0, 1'b0);
    run_phase(1, 65535, 60, 1'b0, 1'b1, 1'b0);
    // zero full scale: span test always passes
    run_phase(0, 100, 60, 1'b1, 1'b1, 1'b0);
    run_phase(1023, 512, 250, 1'b1, 1'b1, 1'b1);
    run_phase(4095, 1000, 250, 1'b1, 1'b1, 1'b0);
    fs_rand = $urandom_range(1, 65535);
    run_phase(fs_rand, $urandom_range(0, fs_rand), 200, 1'b1, 1'b1, 1'b0);
    // closing stretch without idling
    run_phase(2000, 300, 240, 1'b0, 1'b0, 1'b0);

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS line_sensor_position_calibrator");
    end else begin
      $display("FAIL line_sensor_position_calibrator");
    end
    $finish;
  end

endmodule
